FILE: hdl/assert_macros.svh
// Assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, inactive during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/aec_pkg.sv
package aec_pkg;

    localparam int SUM_W  = 42;
    localparam int CNT_W  = 13;
    localparam int DIVD_W = 43;
    localparam int DIVS_W = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_SAMPLES_DEF = 256;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46871;
    localparam logic [15:0] COEF_B = 16'd4732;
    localparam logic [31:0] MIN_ADAPTED  = 32'd7;
    localparam logic [31:0] CHANGE_MIN   = 32'd7;
    localparam logic [31:0] EXPOSURE_ONE = 32'd65536;

    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [15:0] KEY_RST      = 16'd11796;
    localparam logic [15:0] SMOOTH_RST   = 16'd11796;
    localparam logic [15:0] STRENGTH_RST = 16'd42598;

    typedef enum logic [1:0] {
        REG_ENABLE,
        REG_KEY,
        REG_SMOOTHING,
        REG_STRENGTH
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_UPDATED,
        ST_NO_LUMA,
        ST_BELOW_THRESHOLD,
        ST_DISABLED
    } frame_status_t;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        sample_usable;
        logic        last_sample;
    } aec_in_t;

    typedef struct packed {
        logic [31:0]   new_exposure;
        logic          exposure_changed;
        frame_status_t frame_status;
        logic [31:0]   average_luminance;
    } aec_out_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] exposure_key;
        logic [15:0] smoothing;
        logic [15:0] adaptation_strength;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } frame_sum_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_MEAN_GO,
        BK_MEAN_WAIT,
        BK_DECIDE,
        BK_EMA_MUL,
        BK_EMA_ADD,
        BK_CHECK,
        BK_NORM,
        BK_LOG,
        BK_POW_MUL,
        BK_POW_RND,
        BK_EXP,
        BK_SCALE,
        BK_QUOT_GO,
        BK_QUOT_WAIT,
        BK_COMPARE,
        BK_OUT
    } back_state_t;

    typedef logic [15:0][31:0] fact_tab_t;

    // Integer square root, bit-pair method
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_m;
        logic [63:0] rem;
        res   = '0;
        bit_m = 64'h1 << 62;
        rem   = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_m)
            begin
                rem = rem - (res + bit_m);
                res = (res >> 1) + bit_m;
            end
            else
            begin
                res = res >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return res;
    endfunction

    // Q1.30 factors 2^(2^-k), k = 1..16, each the root of the one before
    function automatic fact_tab_t build_exp_factors();
        fact_tab_t   tab;
        logic [63:0] f;
        f = isqrt64(64'h1 << 61);
        tab[0] = f[31:0];
        for (int k = 1; k < 16; k++)
        begin
            f = isqrt64({2'b00, tab[k-1], 30'd0});
            tab[k] = f[31:0];
        end
        return tab;
    endfunction

endpackage

FILE: hdl/aec_front.sv
module aec_front #(
    parameter int MAX_SAMPLES = aec_pkg::MAX_SAMPLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aec_pkg::aec_in_t    in_data,
    output logic                q_push,
    output aec_pkg::frame_sum_t q_data,
    input  logic                q_full
);

    localparam int SW = aec_pkg::SUM_W;
    localparam int CW = aec_pkg::CNT_W;

    logic          a_valid_reg;
    logic          a_last_reg;
    logic          a_use_reg;
    logic [47:0]   prod_r_reg;
    logic [47:0]   prod_g_reg;
    logic [47:0]   prod_b_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic          a_advance;
    logic          in_take;
    logic [49:0]   lum_full;
    logic [31:0]   lum;
    logic [SW:0]   sum_wide;
    logic          take;

    assign a_advance = a_valid_reg && (!a_last_reg || !q_full);
    assign in_ready  = !a_valid_reg || !a_last_reg || !q_full;
    assign in_take   = in_valid && in_ready;

    // Weighted luminance of the staged beat, rounded
    assign lum_full = 50'(prod_r_reg) + 50'(prod_g_reg) + 50'(prod_b_reg) + 50'd32768;
    assign lum      = lum_full[47:16];
    assign sum_wide = {1'b0, sum_reg} + (SW+1)'(lum);
    assign take     = a_use_reg && (count_reg < CW'(MAX_SAMPLES));

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (take)
        begin
            sum_next   = sum_wide[SW] ? aec_pkg::SUM_MAX : sum_wide[SW-1:0];
            count_next = count_reg + CW'(1);
        end
    end

    // Hand the frame totals to the back end on the last beat
    assign q_push       = a_advance && a_last_reg;
    assign q_data.sum   = sum_next;
    assign q_data.count = count_next;

    // Stage valid and frame accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance)
            begin
                if (a_last_reg)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    // Capture products and flags of an accepted beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_last_reg <= in_data.last_sample;
            a_use_reg  <= in_data.sample_usable;
            prod_r_reg <= 48'(in_data.red) * 48'(aec_pkg::COEF_R);
            prod_g_reg <= 48'(in_data.green) * 48'(aec_pkg::COEF_G);
            prod_b_reg <= 48'(in_data.blue) * 48'(aec_pkg::COEF_B);
        end
    end

endmodule

FILE: hdl/aec_fifo.sv
module aec_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aec_pkg::frame_sum_t wr_data,
    output logic                full,
    input  logic                pop,
    output aec_pkg::frame_sum_t rd_data,
    output logic                empty
);

    localparam int DEPTH = aec_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    aec_pkg::frame_sum_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   fill_reg;

    assign full    = (fill_reg == (PW+1)'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/aec_div.sv
module aec_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  aec_pkg::div_req_t                   req,
    output logic                                done,
    output logic [aec_pkg::DIVD_W-1:0]          quotient
);

    localparam int DW = aec_pkg::DIVD_W;
    localparam int VW = aec_pkg::DIVS_W;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;

    logic [VW:0]   rem_sh;
    logic          fits;
    logic [VW:0]   rem_sub;

    // One quotient bit per cycle, restoring
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        end
    end

endmodule

FILE: hdl/aec_back.sv
module aec_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  aec_pkg::cfg_t                     cfg,
    input  logic                              q_empty,
    input  aec_pkg::frame_sum_t               q_data,
    output logic                              q_pop,
    output aec_pkg::div_req_t                 div_req,
    input  logic                              div_done,
    input  logic [aec_pkg::DIVD_W-1:0]        div_quo,
    output logic                              out_valid,
    input  logic                              out_ready,
    output aec_pkg::aec_out_t                 out_data
);

    localparam int DW = aec_pkg::DIVD_W;
    localparam aec_pkg::fact_tab_t EXP_FACTORS = aec_pkg::build_exp_factors();

    aec_pkg::back_state_t   state_reg, state_next;
    aec_pkg::frame_sum_t    ent_reg, ent_next;
    logic [31:0]            mean_reg, mean_next;
    logic [31:0]            filt_reg, filt_next;
    logic [31:0]            cur_reg, cur_next;
    logic [48:0]            prod_a_reg, prod_a_next;
    logic [47:0]            prod_b_reg, prod_b_next;
    logic [31:0]            m_reg, m_next;
    logic [4:0]             e_reg, e_next;
    logic [3:0]             step_reg, step_next;
    logic [15:0]            frac_reg, frac_next;
    logic [37:0]            t_reg, t_next;
    logic                   neg_reg, neg_next;
    logic [5:0]             n_reg, n_next;
    logic [15:0]            r_reg, r_next;
    logic [31:0]            p_reg, p_next;
    logic [31:0]            ad_reg, ad_next;
    logic [31:0]            cand_reg, cand_next;
    aec_pkg::frame_status_t status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    aec_pkg::aec_out_t      out_reg, out_next;

    logic [16:0] w_old;
    logic [49:0] ema_sum;
    logic [63:0] sq;
    logic [5:0]  e_hi;
    logic [21:0] lg;
    logic [21:0] mag;
    logic [37:0] t_rnd;
    logic [21:0] q_mag;
    logic [21:0] y;
    logic [63:0] pm;
    logic [33:0] p_rnd;
    logic [5:0]  s6;
    logic [4:0]  s5;
    logic [33:0] scaled;
    logic [31:0] ad_sat;
    logic [31:0] diff;

    // Datapath terms shared by the sequencer
    assign w_old   = 17'h10000 - 17'(cfg.smoothing);
    assign ema_sum = 50'(prod_a_reg) + 50'(prod_b_reg) + 50'd32768;
    assign sq      = 64'(m_reg) * 64'(m_reg);
    assign e_hi    = 6'({1'b0, e_reg}) - 6'd16;
    assign lg      = {e_hi, frac_reg};
    assign mag     = lg[21] ? (22'd0 - lg) : lg;
    assign t_rnd   = t_reg + 38'd32768;
    assign q_mag   = t_rnd[37:16];
    assign y       = neg_reg ? (22'd0 - q_mag) : q_mag;
    assign pm      = 64'(p_reg) * 64'(EXP_FACTORS[step_reg]);
    assign p_rnd   = pm[63:30] + 34'd0 + 34'(pm[29]);
    assign s6      = 6'd14 - n_reg;
    assign s5      = s6[4:0];
    assign diff    = (cand_reg > cur_reg) ? (cand_reg - cur_reg) : (cur_reg - cand_reg);

    // Final scaling of the power result to Q16.16
    always_comb
    begin
        if ($signed(n_reg) >= 6'sd14)
        begin
            scaled = {2'b00, p_reg} << (n_reg == 6'd15);
        end
        else
        begin
            scaled = ({2'b00, p_reg} + (34'd1 << (s5 - 5'd1))) >> s5;
        end
        ad_sat = (scaled[33:32] != 2'b00) ? 32'hFFFF_FFFF : scaled[31:0];
        if (ad_sat < aec_pkg::MIN_ADAPTED)
        begin
            ad_sat = aec_pkg::MIN_ADAPTED;
        end
    end

    // Sequencer: next state and datapath loads
    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        mean_next      = mean_reg;
        filt_next      = filt_reg;
        cur_next       = cur_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        step_next      = step_reg;
        frac_next      = frac_reg;
        t_next         = t_reg;
        neg_next       = neg_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        ad_next        = ad_reg;
        cand_next      = cand_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        case (state_reg)
            aec_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_data;
                    state_next = aec_pkg::BK_MEAN_GO;
                end
            end
            aec_pkg::BK_MEAN_GO:
            begin
                if (ent_reg.count == '0)
                begin
                    mean_next  = '0;
                    state_next = aec_pkg::BK_DECIDE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(ent_reg.sum) + DW'(ent_reg.count >> 1);
                    div_req.divisor  = 32'(ent_reg.count);
                    state_next       = aec_pkg::BK_MEAN_WAIT;
                end
            end
            aec_pkg::BK_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = (div_quo[DW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
                    state_next = aec_pkg::BK_DECIDE;
                end
            end
            aec_pkg::BK_DECIDE:
            begin
                if (!cfg.enable)
                begin
                    status_next = aec_pkg::ST_DISABLED;
                    state_next  = aec_pkg::BK_OUT;
                end
                else if (ent_reg.count == '0 || mean_reg == '0)
                begin
                    status_next = aec_pkg::ST_NO_LUMA;
                    state_next  = aec_pkg::BK_OUT;
                end
                else if (filt_reg == '0)
                begin
                    filt_next  = mean_reg;
                    state_next = aec_pkg::BK_CHECK;
                end
                else
                begin
                    state_next = aec_pkg::BK_EMA_MUL;
                end
            end
            aec_pkg::BK_EMA_MUL:
            begin
                prod_a_next = 49'(filt_reg) * 49'(w_old);
                prod_b_next = 48'(mean_reg) * 48'(cfg.smoothing);
                state_next  = aec_pkg::BK_EMA_ADD;
            end
            aec_pkg::BK_EMA_ADD:
            begin
                filt_next  = ema_sum[47:16];
                state_next = aec_pkg::BK_CHECK;
            end
            aec_pkg::BK_CHECK:
            begin
                if (filt_reg == '0)
                begin
                    status_next = aec_pkg::ST_NO_LUMA;
                    state_next  = aec_pkg::BK_OUT;
                end
                else
                begin
                    m_next     = filt_reg;
                    e_next     = 5'd31;
                    state_next = aec_pkg::BK_NORM;
                end
            end
            aec_pkg::BK_NORM:
            begin
                // Shift until the leading one reaches the top bit
                if (!m_reg[31] && e_reg != '0)
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
                else
                begin
                    step_next  = '0;
                    frac_next  = '0;
                    state_next = aec_pkg::BK_LOG;
                end
            end
            aec_pkg::BK_LOG:
            begin
                // One fraction bit of log2 per squaring
                frac_next = {frac_reg[14:0], sq[63]};
                m_next    = sq[63] ? sq[63:32] : sq[62:31];
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    state_next = aec_pkg::BK_POW_MUL;
                end
            end
            aec_pkg::BK_POW_MUL:
            begin
                neg_next   = lg[21];
                t_next     = 38'(cfg.adaptation_strength) * 38'(mag);
                state_next = aec_pkg::BK_POW_RND;
            end
            aec_pkg::BK_POW_RND:
            begin
                n_next     = y[21:16];
                r_next     = y[15:0];
                p_next     = 32'h4000_0000;
                step_next  = '0;
                state_next = aec_pkg::BK_EXP;
            end
            aec_pkg::BK_EXP:
            begin
                if (r_reg[~step_reg])
                begin
                    p_next = p_rnd[31:0];
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    state_next = aec_pkg::BK_SCALE;
                end
            end
            aec_pkg::BK_SCALE:
            begin
                ad_next    = ad_sat;
                state_next = aec_pkg::BK_QUOT_GO;
            end
            aec_pkg::BK_QUOT_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DW'({cfg.exposure_key, 16'd0}) + DW'(ad_reg >> 1);
                div_req.divisor  = ad_reg;
                state_next       = aec_pkg::BK_QUOT_WAIT;
            end
            aec_pkg::BK_QUOT_WAIT:
            begin
                if (div_done)
                begin
                    cand_next  = div_quo[31:0];
                    state_next = aec_pkg::BK_COMPARE;
                end
            end
            aec_pkg::BK_COMPARE:
            begin
                if (diff < aec_pkg::CHANGE_MIN)
                begin
                    status_next = aec_pkg::ST_BELOW_THRESHOLD;
                end
                else
                begin
                    cur_next    = cand_reg;
                    status_next = aec_pkg::ST_UPDATED;
                end
                state_next = aec_pkg::BK_OUT;
            end
            aec_pkg::BK_OUT:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_next.new_exposure      = cur_reg;
                    out_next.exposure_changed  = (status_reg == aec_pkg::ST_UPDATED);
                    out_next.frame_status      = status_reg;
                    out_next.average_luminance = mean_reg;
                    state_next                 = aec_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = aec_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aec_pkg::BK_IDLE;
            filt_reg      <= '0;
            cur_reg       <= aec_pkg::EXPOSURE_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filt_reg      <= filt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        mean_reg   <= mean_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        m_reg      <= m_next;
        e_reg      <= e_next;
        step_reg   <= step_next;
        frac_reg   <= frac_next;
        t_reg      <= t_next;
        neg_reg    <= neg_next;
        n_reg      <= n_next;
        r_reg      <= r_next;
        p_reg      <= p_next;
        ad_reg     <= ad_next;
        cand_reg   <= cand_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: hdl/auto_exposure_controller.sv
// Auto exposure controller: frame mean luminance, moving average, power-law key.
// Input channel (in_valid/in_ready/in_data): one RGB sample per beat, Q16.16,
// with a usable flag and a last flag closing the frame. Samples are taken one
// per cycle; the front end stalls only when a last beat finds the two-entry
// frame queue full.
// Output channel (out_valid/out_ready/out_data): one beat per frame, carrying
// the exposure, change flag, status and mean luminance.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no frame is in flight.
// The back end works on one frame at a time; a full update makes two passes
// of the shared radix-2 divider, runs a leading-one search and two 16-step
// multiply sequences for log2 and exp2. A stalled receiver holds the result
// in the output register; the front end keeps accepting samples until a last
// beat finds the queue holding two finished frames.
// Reset clears the queue, the filter history and sets exposure to one.
module auto_exposure_controller #(
    parameter int MAX_SAMPLES = aec_pkg::MAX_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aec_pkg::aec_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aec_pkg::aec_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    aec_pkg::cfg_t        cfg_reg;
    aec_pkg::frame_sum_t  push_data;
    aec_pkg::frame_sum_t  pop_data;
    aec_pkg::div_req_t    div_req;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic                 div_done;
    logic [aec_pkg::DIVD_W-1:0] div_quo;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable              <= aec_pkg::ENABLE_RST;
            cfg_reg.exposure_key        <= aec_pkg::KEY_RST;
            cfg_reg.smoothing           <= aec_pkg::SMOOTH_RST;
            cfg_reg.adaptation_strength <= aec_pkg::STRENGTH_RST;
        end
        else if (cfg_valid)
        begin
            case (aec_pkg::cfg_reg_t'(cfg_index))
                aec_pkg::REG_ENABLE:    cfg_reg.enable              <= cfg_data[0];
                aec_pkg::REG_KEY:       cfg_reg.exposure_key        <= cfg_data;
                aec_pkg::REG_SMOOTHING: cfg_reg.smoothing           <= cfg_data;
                aec_pkg::REG_STRENGTH:  cfg_reg.adaptation_strength <= cfg_data;
                default:                cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    aec_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_data   (push_data),
        .q_full   (q_full)
    );

    aec_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (pop_data),
        .empty   (q_empty)
    );

    aec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    aec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_done  (div_done),
        .div_quo   (div_quo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hdl/aec_checker.sv
`include "assert_macros.svh"

module aec_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input aec_pkg::aec_out_t out_data
);

    // A waiting result beat stays offered
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

    // The change flag follows the status code
    `ASSERT_IMPLIES(a_flag_status, out_valid, out_data.exposure_changed == (out_data.frame_status == aec_pkg::ST_UPDATED), "change flag disagrees with status")

    // A frame that did not update keeps the exposure of the beat before
    `ASSERT_NEXT(a_keep_exp, out_valid && out_ready, !out_valid || out_data.exposure_changed || out_data.new_exposure == $past(out_data.new_exposure), "exposure moved without update")

endmodule

bind auto_exposure_controller aec_checker u_aec_checker (.*);
